// ===== hdl/window_layer_order_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Window layer order table assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LAYER_ORDER_TABLE_TOP_MACROS_SVH
`define WINDOW_LAYER_ORDER_TABLE_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WLOT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define WLOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wlot_pkg.sv =====
// ----------------------------------------------------------------------------
// Window layer order table package
// Field widths, command codes, status codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package wlot_pkg;

  localparam int FUNC_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int LAYER_W  = 7;
  localparam int STATUS_W = 2;

  localparam int GRP   = 8;
  localparam int GRP_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RAISE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOWER  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DELETE,
    OP_RAISE,
    OP_LOWER,
    OP_CLEAR,
    OP_QUERY,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_APPLY
  } bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/wlot_front.sv =====
// ----------------------------------------------------------------------------
// Window layer order table front end
// Accepts commands and classifies the function code for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wlot_front (
  input  logic                          start,
  input  logic [wlot_pkg::FUNC_W-1:0]   func,
  input  logic [wlot_pkg::SLOT_W-1:0]   slot_id,
  input  wlot_pkg::q_stat_t             q_stat,
  output logic                          busy,
  output logic                          push,
  output wlot_pkg::cmd_t                cmd
);
  import wlot_pkg::*;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    cmd.slot = slot_id;
    unique case (func)
      FUNC_CREATE: cmd.op = OP_CREATE;
      FUNC_DELETE: cmd.op = OP_DELETE;
      FUNC_RAISE:  cmd.op = OP_RAISE;
      FUNC_LOWER:  cmd.op = OP_LOWER;
      FUNC_CLEAR:  cmd.op = OP_CLEAR;
      FUNC_QUERY:  cmd.op = OP_QUERY;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/wlot_queue.sv =====
// ----------------------------------------------------------------------------
// Window layer order table command queue
// Two-entry queue between the front end and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wlot_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wlot_pkg::cmd_t    wr_cmd,
  input  logic              pop,
  output wlot_pkg::cmd_t    rd_cmd,
  output wlot_pkg::q_stat_t q_stat
);
  import wlot_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  assign rd_cmd       = entry[rd_ptr];
  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);

endmodule

`default_nettype wire

// ===== hdl/wlot_back.sv =====
// ----------------------------------------------------------------------------
// Window layer order table engine
// Holds one layer cell per slot; applies each command via lookup and apply.
// ----------------------------------------------------------------------------
`default_nettype none

module wlot_back #(
  parameter int SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wlot_pkg::q_stat_t                q_stat,
  input  wlot_pkg::cmd_t                   rd_cmd,
  output logic                             pop,
  output logic                             done,
  output logic [wlot_pkg::SLOT_W-1:0]      slot_out,
  output logic [wlot_pkg::LAYER_W-1:0]     layer_out,
  output logic                             changed,
  output logic [wlot_pkg::STATUS_W-1:0]    status,
  output logic [$clog2(SLOTS+1)-1:0]       open_count
);
  import wlot_pkg::*;

  localparam int LW   = $clog2(SLOTS + 1);
  localparam int IDXW = $clog2(SLOTS);
  localparam int CMPW = (IDXW > SLOT_W) ? IDXW : SLOT_W;
  localparam int NG   = (SLOTS + GRP - 1) / GRP;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int FIW  = GIW + GRP_W;

  bk_state_t           state;
  bk_state_t           state_next;
  cmd_t                cmd;
  logic [LW-1:0]       layer      [SLOTS];
  logic [LW-1:0]       layer_next [SLOTS];
  logic [LW-1:0]       open_count_next;

  logic [NG*GRP-1:0]   empty_vec;
  logic [LW-1:0]       look_layer;
  logic [NG-1:0]       grp_free_c;
  logic [GRP_W-1:0]    grp_idx_c [NG];

  logic [LW-1:0]       old_layer;
  logic                is_open;
  logic [NG-1:0]       grp_free;
  logic [GRP_W-1:0]    grp_idx [NG];

  logic                new_found;
  logic [FIW-1:0]      new_idx;
  logic [LW-1:0]       cnt_plus;
  logic [FIW+SLOT_W-1:0]   slot_ext;
  logic [SLOT_W-1:0]       res_slot;
  logic [LW-1:0]           res_layer;
  logic [LW+LAYER_W-1:0]   layer_ext;
  logic                    res_chg;
  logic [STATUS_W-1:0]     res_st;

  for (genvar k = 0; k < NG * GRP; k++) begin : g_empty
    if (k < SLOTS) begin : g_cell
      assign empty_vec[k] = (layer[k] == '0);
    end else begin : g_pad
      assign empty_vec[k] = 1'b0;
    end
  end

  always_comb begin
    look_layer = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CMPW'(i) == CMPW'(cmd.slot)) begin
        look_layer = look_layer | layer[i];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free_c[g] = 1'b0;
      grp_idx_c[g]  = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (empty_vec[g*GRP+j]) begin
          grp_free_c[g] = 1'b1;
          grp_idx_c[g]  = GRP_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    old_layer <= look_layer;
    is_open   <= (look_layer != '0);
    grp_free  <= grp_free_c;
    grp_idx   <= grp_idx_c;
  end

  always_comb begin
    new_found = 1'b0;
    new_idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        new_found = 1'b1;
        new_idx   = {GIW'(g), grp_idx[g]};
      end
    end
  end

  assign cnt_plus  = open_count + LW'(1);
  assign slot_ext  = (FIW + SLOT_W)'(new_idx);
  assign layer_ext = (LW + LAYER_W)'(res_layer);

  always_comb begin
    open_count_next = open_count;
    for (int i = 0; i < SLOTS; i++) begin
      layer_next[i] = layer[i];
    end
    if (state == BK_APPLY) begin
      unique case (cmd.op)
        OP_CREATE: begin
          if (new_found) begin
            open_count_next = cnt_plus;
            for (int i = 0; i < SLOTS; i++) begin
              if (FIW'(i) == new_idx) begin
                layer_next[i] = cnt_plus;
              end
            end
          end
        end
        OP_DELETE: begin
          if (is_open) begin
            open_count_next = open_count - LW'(1);
            for (int i = 0; i < SLOTS; i++) begin
              if (CMPW'(i) == CMPW'(cmd.slot)) begin
                layer_next[i] = '0;
              end else if (layer[i] > old_layer) begin
                layer_next[i] = layer[i] - LW'(1);
              end
            end
          end
        end
        OP_RAISE: begin
          if (is_open) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (CMPW'(i) == CMPW'(cmd.slot)) begin
                layer_next[i] = open_count;
              end else if (layer[i] > old_layer) begin
                layer_next[i] = layer[i] - LW'(1);
              end
            end
          end
        end
        OP_LOWER: begin
          if (is_open) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (CMPW'(i) == CMPW'(cmd.slot)) begin
                layer_next[i] = LW'(1);
              end else if (layer[i] != '0 && layer[i] < old_layer) begin
                layer_next[i] = layer[i] + LW'(1);
              end
            end
          end
        end
        OP_CLEAR: begin
          open_count_next = '0;
          for (int i = 0; i < SLOTS; i++) begin
            layer_next[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_slot  = cmd.slot;
    res_layer = '0;
    res_chg   = 1'b0;
    res_st    = ST_OK;
    unique case (cmd.op)
      OP_CREATE: begin
        if (new_found) begin
          res_slot  = slot_ext[SLOT_W-1:0];
          res_layer = cnt_plus;
          res_chg   = 1'b1;
        end else begin
          res_slot = '0;
          res_st   = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (is_open) begin
          res_chg = 1'b1;
        end else begin
          res_st = ST_ABSENT;
        end
      end
      OP_RAISE: begin
        if (is_open) begin
          res_layer = open_count;
          res_chg   = (old_layer != open_count);
        end else begin
          res_st = ST_ABSENT;
        end
      end
      OP_LOWER: begin
        if (is_open) begin
          res_layer = LW'(1);
          res_chg   = (old_layer != LW'(1));
        end else begin
          res_st = ST_ABSENT;
        end
      end
      OP_CLEAR: begin
        res_chg = (open_count != '0);
      end
      OP_QUERY: begin
        if (is_open) begin
          res_layer = old_layer;
        end else begin
          res_st = ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_LOOK;
        end
      end
      BK_LOOK: begin
        state_next = BK_APPLY;
      end
      BK_APPLY: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_LOOK;
        end else begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      done       <= 1'b0;
      open_count <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        layer[i] <= '0;
      end
    end else begin
      state      <= state_next;
      done       <= (state == BK_APPLY);
      open_count <= open_count_next;
      for (int i = 0; i < SLOTS; i++) begin
        layer[i] <= layer_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= rd_cmd;
    end
    if (state == BK_APPLY) begin
      slot_out  <= res_slot;
      layer_out <= layer_ext[LAYER_W-1:0];
      changed   <= res_chg;
      status    <= res_st;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/window_layer_order_table_top.sv =====
// ----------------------------------------------------------------------------
// Window layer order table
// Z-order table of window slots with create, delete, raise, lower, clear and
// query commands.
// ----------------------------------------------------------------------------
// A command is transferred on a rising edge where start is high and busy is
// low; func and slot_id are sampled on that edge. Commands go into a
// two-entry queue, and busy is high while that queue is full.
// The engine takes one command from the queue, reads the slot cells in a
// lookup cycle and writes them in an apply cycle, popping the next command
// in the apply cycle if the queue holds one. Each result is registered out
// of the apply cycle: done is high for exactly one cycle with slot_out,
// layer_out, changed and status valid in that cycle.
// The receiver cannot stall; every result must be taken in its done cycle.
// Reset empties every slot and the queue at once, and the block takes
// commands in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_layer_order_table_top_macros.svh"

module window_layer_order_table_top #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [wlot_pkg::FUNC_W-1:0]    func,
  input  logic [wlot_pkg::SLOT_W-1:0]    slot_id,
  output logic                           done,
  output logic [wlot_pkg::SLOT_W-1:0]    slot_out,
  output logic [wlot_pkg::LAYER_W-1:0]   layer_out,
  output logic                           changed,
  output logic [wlot_pkg::STATUS_W-1:0]  status
);
  import wlot_pkg::*;

  localparam int LW = $clog2(SLOTS + 1);

  q_stat_t       q_stat;
  logic          push;
  logic          pop;
  cmd_t          wr_cmd;
  cmd_t          rd_cmd;
  logic [LW-1:0] open_count;

  wlot_front u_front (
    .start   (start),
    .func    (func),
    .slot_id (slot_id),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .cmd     (wr_cmd)
  );

  wlot_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .q_stat (q_stat)
  );

  wlot_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .rd_cmd     (rd_cmd),
    .pop        (pop),
    .done       (done),
    .slot_out   (slot_out),
    .layer_out  (layer_out),
    .changed    (changed),
    .status     (status),
    .open_count (open_count)
  );

  `WLOT_ASSERT_SAME(a_count_bound, 1'b1, int'(open_count) <= SLOTS, "open count above slot count")
  `WLOT_ASSERT_SAME(a_full_count, done && status == ST_FULL, int'(open_count) == SLOTS, "full with free slot")
  `WLOT_ASSERT_NEXT(a_done_spacing, done, !done, "results closer than two cycles")
  `WLOT_ASSERT_NEXT(a_transfer_queued, start && !busy, !q_stat.empty, "transferred command not queued")

endmodule

`default_nettype wire

// ===== bench/window_layer_order_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// Window layer order table testbench
// Sends create, delete, raise, lower, clear and query commands, first a short
// directed list and then random sequences that fill, reorder and empty the
// table. A local copy of the layer table predicts each result, and every
// result is checked against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module window_layer_order_table_top_tb;
  import wlot_pkg::*;

  localparam int SLOTS        = 64;
  localparam int ITEM_TARGET  = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
  } window_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [LAYER_W-1:0]  layer;
    logic                changed;
    logic [STATUS_W-1:0] status;
  } layer_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [FUNC_W-1:0]   func = '0;
  logic [SLOT_W-1:0]   slot_id = '0;
  logic                busy;
  logic                done;
  logic [SLOT_W-1:0]   slot_out;
  logic [LAYER_W-1:0]  layer_out;
  logic                changed;
  logic [STATUS_W-1:0] status;

  window_cmd_t        pending_cmds[$];
  layer_reply_t       expected_replies[$];
  logic [LAYER_W-1:0] stack_layer [SLOTS];
  logic [LAYER_W-1:0] open_windows;
  bit                 plan_open [SLOTS];
  window_cmd_t        next_cmd;
  layer_reply_t       predicted_reply;
  layer_reply_t       seen_reply;
  layer_reply_t       want_reply;
  int                 transfers = 0;
  int                 mismatches = 0;
  int                 cycles = 0;
  logic               steady;

  assign steady = (transfers >= 200) && (transfers < 300);

  window_layer_order_table_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .func     (func),
    .slot_id  (slot_id),
    .done     (done),
    .slot_out (slot_out),
    .layer_out(layer_out),
    .changed  (changed),
    .status   (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic layer_reply_t apply_layer_cmd(window_cmd_t c);
    layer_reply_t       r;
    logic [LAYER_W-1:0] old;
    bit                 found;
    r = '{slot: c.slot, layer: '0, changed: 1'b0, status: ST_OK};
    found = 1'b0;
    case (c.func)
      FUNC_CREATE: begin
        r.slot = '0;
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (stack_layer[i] == '0) begin
            open_windows = open_windows + 1'b1;
            stack_layer[i] = open_windows;
            r.slot = SLOT_W'(i);
            r.layer = open_windows;
            r.changed = 1'b1;
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      FUNC_DELETE, FUNC_RAISE, FUNC_LOWER: begin
        old = stack_layer[c.slot];
        if (old == '0) begin
          r.status = ST_ABSENT;
        end else begin
          if (c.func == FUNC_DELETE) begin
            stack_layer[c.slot] = '0;
            for (int i = 0; i < SLOTS; i++) begin
              if (i != c.slot && stack_layer[i] != '0 && stack_layer[i] >= old &&
                  stack_layer[i] <= open_windows) begin
                stack_layer[i] = stack_layer[i] - 1'b1;
              end
            end
            open_windows = open_windows - 1'b1;
            r.changed = 1'b1;
          end else if (c.func == FUNC_RAISE) begin
            if (old != open_windows) begin
              stack_layer[c.slot] = open_windows;
              for (int i = 0; i < SLOTS; i++) begin
                if (i != c.slot && stack_layer[i] != '0 && stack_layer[i] >= old &&
                    stack_layer[i] <= open_windows) begin
                  stack_layer[i] = stack_layer[i] - 1'b1;
                end
              end
              r.changed = 1'b1;
            end
          end else begin
            if (old != 1) begin
              stack_layer[c.slot] = LAYER_W'(1);
              for (int i = 0; i < SLOTS; i++) begin
                if (i != c.slot && stack_layer[i] != '0 && stack_layer[i] <= old) begin
                  stack_layer[i] = stack_layer[i] + 1'b1;
                end
              end
              r.changed = 1'b1;
            end
          end
          r.layer = stack_layer[c.slot];
        end
      end
      FUNC_CLEAR: begin
        r.changed = (open_windows != '0);
        for (int i = 0; i < SLOTS; i++) stack_layer[i] = '0;
        open_windows = '0;
      end
      FUNC_QUERY: begin
        if (stack_layer[c.slot] != '0) r.layer = stack_layer[c.slot];
        else r.status = ST_ABSENT;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic plan_cmd(input logic [FUNC_W-1:0] f, input int s);
    bit          taken;
    window_cmd_t c;
    taken = 1'b0;
    c.func = f;
    c.slot = SLOT_W'(s);
    pending_cmds.insert(pending_cmds.size(), c);
    case (f)
      FUNC_CREATE: begin
        for (int i = 0; i < SLOTS && !taken; i++) begin
          if (!plan_open[i]) begin
            plan_open[i] = 1'b1;
            taken = 1'b1;
          end
        end
      end
      FUNC_DELETE: plan_open[s] = 1'b0;
      FUNC_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) plan_open[i] = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic int planned_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += plan_open[i];
    return n;
  endfunction

  function automatic int pick_slot();
    int open_list[$];
    for (int i = 0; i < SLOTS; i++) if (plan_open[i]) open_list.insert(open_list.size(), i);
    if (open_list.size() > 0 && $urandom_range(9) < 8) begin
      return open_list[$urandom_range(open_list.size() - 1)];
    end
    return $urandom_range(SLOTS - 1);
  endfunction

  task automatic fill_table();
    int extra;
    extra = SLOTS - planned_count() + 1 + $urandom_range(2);
    repeat (extra) plan_cmd(FUNC_CREATE, $urandom_range(SLOTS - 1));
  endtask

  task automatic build_stimulus();
    int                r;
    bit                filled;
    logic [FUNC_W-1:0] f;
    filled = 1'b0;

    plan_cmd(FUNC_QUERY, 0);
    plan_cmd(FUNC_DELETE, 0);
    plan_cmd(FUNC_RAISE, 63);
    plan_cmd(FUNC_LOWER, 5);
    plan_cmd(FUNC_CLEAR, 0);
    plan_cmd(FUNC_SPARE_A, 42);
    plan_cmd(FUNC_SPARE_B, 21);
    repeat (4) plan_cmd(FUNC_CREATE, 63);
    plan_cmd(FUNC_RAISE, 3);
    plan_cmd(FUNC_LOWER, 0);
    plan_cmd(FUNC_RAISE, 0);
    plan_cmd(FUNC_LOWER, 3);
    plan_cmd(FUNC_QUERY, 0);
    plan_cmd(FUNC_QUERY, 3);
    plan_cmd(FUNC_DELETE, 1);
    plan_cmd(FUNC_CREATE, 0);
    plan_cmd(FUNC_DELETE, 0);
    plan_cmd(FUNC_RAISE, 63);
    plan_cmd(FUNC_CLEAR, 7);
    plan_cmd(FUNC_QUERY, 2);

    while (pending_cmds.size() < ITEM_TARGET) begin
      r = $urandom_range(99);
      if ((!filled && pending_cmds.size() > 250) || r == 0) begin
        fill_table();
        filled = 1'b1;
      end else if (r < 4) begin
        plan_cmd(FUNC_CLEAR, $urandom_range(SLOTS - 1));
      end else begin
        r = $urandom_range(99);
        if (r < 28) f = FUNC_CREATE;
        else if (r < 44) f = FUNC_DELETE;
        else if (r < 60) f = FUNC_RAISE;
        else if (r < 76) f = FUNC_LOWER;
        else if (r < 95) f = FUNC_QUERY;
        else if (r < 98) f = FUNC_SPARE_A;
        else f = FUNC_SPARE_B;
        plan_cmd(f, pick_slot());
      end
    end
  endtask

  // A command waiting on busy is held unchanged until its transfer.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        predicted_reply = apply_layer_cmd('{func: func, slot: slot_id});
        expected_replies.insert(expected_replies.size(), predicted_reply);
        transfers++;
      end
      if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
        next_cmd = pending_cmds.pop_front();
        func <= next_cmd.func;
        slot_id <= next_cmd.slot;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_reply = '{slot: slot_out, layer: layer_out, changed: changed, status: status};
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: slot %0d layer %0d changed %0d status %0d",
                   slot_out, layer_out, changed, status);
        end
      end else begin
        want_reply = expected_replies.pop_front();
        if (seen_reply !== want_reply) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected slot %0d layer %0d changed %0d status %0d,",
                     want_reply.slot, want_reply.layer, want_reply.changed,
                     want_reply.status);
            $display("  got slot %0d layer %0d changed %0d status %0d",
                     seen_reply.slot, seen_reply.layer, seen_reply.changed,
                     seen_reply.status);
          end
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      stack_layer[i] = '0;
      plan_open[i] = 1'b0;
    end
    open_windows = '0;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() > 0 || start);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
